FILE: rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// shared widths, register indexes, reset values and control types for the
// calibrated moving average block
// ----------------------------------------------------------------------------
package cma_pkg;

	localparam int DATA_W    = 32;
	localparam int RAW_W     = 12;
	localparam int WIN_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = DATA_W + RAW_W + 1;
	localparam int CSUM_W    = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

	localparam logic signed [DATA_W-1:0] GAIN_RST   = 32'sd65536;
	localparam logic signed [DATA_W-1:0] OFFSET_RST = 32'sd0;
	localparam logic [WIN_W-1:0]         WINDOW_RST = 5'd16;

	localparam logic signed [DATA_W-1:0] CAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] CAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic shift;
		logic incl;
	} cma_ctl_t;

endpackage

FILE: rtl/cma_cell.sv
// ----------------------------------------------------------------------------
// cma_cell
// one delay line entry plus one adder stage of the window sum token
// ----------------------------------------------------------------------------
module cma_cell #(
	parameter int SUM_W = 36
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cma_pkg::cma_ctl_t                      ctl,
	input  logic signed [cma_pkg::DATA_W-1:0]      hist_in,
	output logic signed [cma_pkg::DATA_W-1:0]      hist_out,
	input  logic signed [SUM_W-1:0]                acc_in,
	input  logic                                   acc_vld_in,
	output logic signed [SUM_W-1:0]                acc_out,
	output logic                                   acc_vld_out
);

	logic signed [cma_pkg::DATA_W-1:0] hist_q;
	logic signed [SUM_W-1:0]           acc_q;
	logic                              acc_vld_q;
	logic signed [SUM_W-1:0]           hist_ext;

	assign hist_ext = ctl.incl ? SUM_W'(hist_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= '0;
			acc_vld_q <= 1'b0;
		end else begin
			acc_vld_q <= acc_vld_in;
			if (ctl.shift) begin
				hist_q <= hist_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_in + hist_ext;
	end

	assign hist_out    = hist_q;
	assign acc_out     = acc_q;
	assign acc_vld_out = acc_vld_q;

endmodule

FILE: rtl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// bit-serial restoring divider, signed sum by window count, truncated
// toward zero
// ----------------------------------------------------------------------------
module cma_div #(
	parameter int SUM_W = 36,
	parameter int NW    = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SUM_W-1:0]           dividend,
	input  logic [NW-1:0]                     divisor,
	output logic                              done,
	output logic [cma_pkg::DATA_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [NW-1:0]    dvs_q;
	logic             neg_q;

	logic [NW:0]      r2;
	logic             ge;
	logic [NW:0]      nrem;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] qs;

	assign r2   = {rem_q, quo_q[SUM_W-1]};
	assign ge   = (r2 >= {1'b0, dvs_q});
	assign nrem = ge ? (r2 - {1'b0, dvs_q}) : r2;
	assign mag  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign qs   = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= nrem[NW-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = qs[cma_pkg::DATA_W-1:0];

endmodule

FILE: rtl/calibrated_moving_average.sv
// ----------------------------------------------------------------------------
// calibrated_moving_average
// calibrates raw converter samples (gain * sample + offset, saturated) and
// returns the boxcar mean of the newest window_length calibrated values
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    raw_sample
//   out      source     out_valid / out_stall  average
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// one item at a time: after input transfer the sum token walks the cell row
// and the bit-serial divider runs until the result sits in the output
// register; the next input is taken once the result is loaded into the
// output register. reset clears the delay line and the state, control and
// configuration registers at once, with no clearing pass. a stalled result
// holds and does not block the next item until that one is ready to be
// loaded.
// ----------------------------------------------------------------------------
module calibrated_moving_average #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cma_pkg::RAW_W-1:0]             raw_sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cma_pkg::DATA_W-1:0]     average,
	input  logic                                  cfg_we,
	input  logic [cma_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cma_pkg::DATA_W-1:0]            cfg_data
);

	localparam int SUM_W = cma_pkg::DATA_W + $clog2(MAX_WINDOW);
	localparam int NW    = $clog2(MAX_WINDOW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CAL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                            state_q;
	logic signed [cma_pkg::DATA_W-1:0]     gain_q;
	logic signed [cma_pkg::DATA_W-1:0]     offset_q;
	logic [cma_pkg::WIN_W-1:0]             win_q;
	logic signed [cma_pkg::PROD_W-1:0]     prod_s1;
	logic                                  start_q;
	logic                                  out_valid_q;
	logic signed [cma_pkg::DATA_W-1:0]     average_q;

	logic signed [cma_pkg::CSUM_W-1:0]     csum;
	logic signed [cma_pkg::DATA_W-1:0]     cal;
	logic [NW-1:0]                         n;
	logic                                  in_xfer;
	logic                                  out_load;
	logic                                  div_done;
	logic [cma_pkg::DATA_W-1:0]            quotient;

	logic signed [cma_pkg::DATA_W-1:0]     hist  [0:MAX_WINDOW];
	logic signed [SUM_W-1:0]               acc   [0:MAX_WINDOW];
	logic                                  vld   [0:MAX_WINDOW];
	cma_pkg::cma_ctl_t                     ctl   [0:MAX_WINDOW-1];

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign n = (win_q == '0) ? NW'(1) :
		((32'(win_q) > MAX_WINDOW) ? NW'(MAX_WINDOW) : NW'(win_q));

	// calibration, saturated to 32 bits
	assign csum = cma_pkg::CSUM_W'(prod_s1) + cma_pkg::CSUM_W'(offset_q);
	always_comb begin
		if (csum > cma_pkg::CSUM_W'(cma_pkg::CAL_MAX)) begin
			cal = cma_pkg::CAL_MAX;
		end else if (csum < cma_pkg::CSUM_W'(cma_pkg::CAL_MIN)) begin
			cal = cma_pkg::CAL_MIN;
		end else begin
			cal = csum[cma_pkg::DATA_W-1:0];
		end
	end

	assign hist[0] = cal;
	assign acc[0]  = '0;
	assign vld[0]  = start_q;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		assign ctl[i].shift = (state_q == ST_CAL);
		assign ctl[i].incl  = (NW'(i) < n);
		cma_cell #(
			.SUM_W(SUM_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[i]),
			.hist_in     (hist[i]),
			.hist_out    (hist[i+1]),
			.acc_in      (acc[i]),
			.acc_vld_in  (vld[i]),
			.acc_out     (acc[i+1]),
			.acc_vld_out (vld[i+1])
		);
	end

	cma_div #(
		.SUM_W(SUM_W),
		.NW   (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_SUM) && vld[MAX_WINDOW]),
		.dividend (acc[MAX_WINDOW]),
		.divisor  (n),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= cma_pkg::GAIN_RST;
			offset_q    <= cma_pkg::OFFSET_RST;
			win_q       <= cma_pkg::WINDOW_RST;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_CAL);
			if (cfg_we) begin
				case (cfg_index)
					cma_pkg::REG_GAIN:   gain_q   <= cfg_data;
					cma_pkg::REG_OFFSET: offset_q <= cfg_data;
					cma_pkg::REG_WINDOW: win_q    <= cfg_data[cma_pkg::WIN_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CAL;
					end
				end
				ST_CAL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (vld[MAX_WINDOW]) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			prod_s1 <= gain_q * $signed({1'b0, raw_sample});
		end
		if (out_load) begin
			average_q <= quotient;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

endmodule
